@@ rtl/sidad_pkg.sv @@
// sidad_pkg: shared widths, character codes, fsm states and control struct
// for the signed integer to decimal ascii converter; no dependencies
package sidad_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int BCD_WIDTH   = 4 * NUM_DIGITS;
	localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
	localparam int NDIG_W      = $clog2(NUM_DIGITS + 1);
	localparam int CHAR_W      = 6;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic shift_in;
		logic bit_in;
		logic shift_out;
	} bcd_ctrl_t;

endpackage

@@ rtl/signed_int_to_decimal_ascii.sv @@
// signed_int_to_decimal_ascii: renders a signed integer as decimal ascii text,
// one character per output transfer; uses sidad_pkg and sidad_bcd
// conversion: the magnitude is shifted into bcd one bit at a time, then leading
// zero digits are skipped (up to 9), and a minus sign, if any, precedes the digits
// throughput: one value at a time; the next is accepted after its last character is loaded
// reset: asynchronous active low, clears the fsm and the output valid
module signed_int_to_decimal_ascii (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic signed [sidad_pkg::VALUE_WIDTH-1:0] value,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	output logic [sidad_pkg::CHAR_W-1:0]         ascii_char,
	output logic                                 last_char,
	output logic                                 out_valid,
	input  logic                                 out_stall
);

	localparam int W = sidad_pkg::VALUE_WIDTH;

	sidad_pkg::state_t state_q, next_state;
	sidad_pkg::bcd_ctrl_t bcd_ctrl;

	logic [W-1:0]                     mag_q;
	logic                             neg_q;
	logic [sidad_pkg::BIT_CNT_W-1:0]  bit_cnt_q;
	logic [sidad_pkg::NDIG_W-1:0]     ndig_q;
	logic [3:0]                       top_digit;
	logic [sidad_pkg::CHAR_W-1:0]     ascii_char_q, out_char;
	logic                             last_char_q, out_last;
	logic                             out_valid_q;
	logic                             accept, out_free, out_load, skip_zero, ndig_one;

	assign accept    = in_valid && (state_q == sidad_pkg::ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign ndig_one  = (ndig_q == sidad_pkg::NDIG_W'(1));
	assign skip_zero = (top_digit == 4'd0) && !ndig_one;

	sidad_bcd u_bcd (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (bcd_ctrl),
		.top_digit (top_digit)
	);

	// next state
	always_comb begin
		next_state = state_q;
		case (state_q)
			sidad_pkg::ST_IDLE: begin
				if (accept) next_state = sidad_pkg::ST_CONV;
			end
			sidad_pkg::ST_CONV: begin
				if (bit_cnt_q == '0) next_state = sidad_pkg::ST_SKIP;
			end
			sidad_pkg::ST_SKIP: begin
				if (!skip_zero) next_state = neg_q ? sidad_pkg::ST_SIGN : sidad_pkg::ST_EMIT;
			end
			sidad_pkg::ST_SIGN: begin
				if (out_free) next_state = sidad_pkg::ST_EMIT;
			end
			sidad_pkg::ST_EMIT: begin
				if (out_free && ndig_one) next_state = sidad_pkg::ST_IDLE;
			end
			default: next_state = sidad_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall           = 1'b1;
		bcd_ctrl.clear     = 1'b0;
		bcd_ctrl.shift_in  = 1'b0;
		bcd_ctrl.bit_in    = mag_q[W-1];
		bcd_ctrl.shift_out = 1'b0;
		out_load           = 1'b0;
		out_char           = sidad_pkg::CHAR_ZERO | {2'b00, top_digit};
		out_last           = 1'b0;
		case (state_q)
			sidad_pkg::ST_IDLE: begin
				in_stall       = 1'b0;
				bcd_ctrl.clear = accept;
			end
			sidad_pkg::ST_CONV: begin
				bcd_ctrl.shift_in = 1'b1;
			end
			sidad_pkg::ST_SKIP: begin
				bcd_ctrl.shift_out = skip_zero;
			end
			sidad_pkg::ST_SIGN: begin
				out_load = out_free;
				out_char = sidad_pkg::CHAR_MINUS;
			end
			sidad_pkg::ST_EMIT: begin
				out_load           = out_free;
				out_last           = ndig_one;
				bcd_ctrl.shift_out = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sidad_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= next_state;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q     <= value[W-1];
			mag_q     <= value[W-1] ? (~value + W'(1)) : value;
			bit_cnt_q <= sidad_pkg::BIT_CNT_W'(W - 1);
			ndig_q    <= sidad_pkg::NDIG_W'(sidad_pkg::NUM_DIGITS);
		end else begin
			if (bcd_ctrl.shift_in) begin
				mag_q     <= {mag_q[W-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q - sidad_pkg::BIT_CNT_W'(1);
			end
			if (bcd_ctrl.shift_out) begin
				ndig_q <= ndig_q - sidad_pkg::NDIG_W'(1);
			end
		end
		if (out_load) begin
			ascii_char_q <= out_char;
			last_char_q  <= out_last;
		end
	end

	assign ascii_char = ascii_char_q;
	assign last_char  = last_char_q;
	assign out_valid  = out_valid_q;

endmodule

@@ rtl/sidad_bcd.sv @@
// sidad_bcd: bcd digit register, double dabble one magnitude bit per cycle on
// shift_in and shift out one digit per cycle on shift_out, msd first; uses sidad_pkg
module sidad_bcd (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sidad_pkg::bcd_ctrl_t ctrl,
	output logic [3:0]           top_digit
);

	logic [sidad_pkg::BCD_WIDTH-1:0] bcd_q;
	logic [sidad_pkg::BCD_WIDTH-1:0] adj_bcd;

	always_comb begin
		for (int i = 0; i < sidad_pkg::NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj_bcd[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj_bcd[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcd_q <= '0;
		end else if (ctrl.clear) begin
			bcd_q <= '0;
		end else if (ctrl.shift_in) begin
			bcd_q <= {adj_bcd[sidad_pkg::BCD_WIDTH-2:0], ctrl.bit_in};
		end else if (ctrl.shift_out) begin
			bcd_q <= {bcd_q[sidad_pkg::BCD_WIDTH-5:0], 4'd0};
		end
	end

	assign top_digit = bcd_q[sidad_pkg::BCD_WIDTH-1 -: 4];

endmodule
